// ----- rtl/core/clbw_pkg.sv -----
// Package for the cylinder lattice bond and angle walker.
// Holds sizes, register indexes, shared structs and the offset helper.
// No dependencies.
`default_nettype none
package clbw_pkg;

    localparam int MAX_STRANDS     = 64;
    localparam int MAX_RING_MASSES = 256;
    localparam int COORD_DIM       = 3;

    localparam int SCFG_W   = 7;
    localparam int MCFG_W   = 9;
    localparam int OFFSET_W = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam int STRAND_W = $clog2(MAX_STRANDS);
    localparam int RING_W   = $clog2(MAX_RING_MASSES);
    localparam int ESC_W    = STRAND_W + 1;
    localparam int EMC_W    = RING_W + 1;
    localparam int MASS_W   = $clog2(MAX_STRANDS * MAX_RING_MASSES + MAX_RING_MASSES);
    localparam int DIM_W    = $clog2(COORD_DIM + 1);
    localparam int PROD_W   = MASS_W + DIM_W;

    typedef enum logic {
        REG_STRAND_COUNT = 1'b0,
        REG_MASSES       = 1'b1
    } t_reg_idx;

    typedef enum logic {
        PHASE_BOND  = 1'b0,
        PHASE_ANGLE = 1'b1
    } t_phase;

    typedef enum logic {
        KIND_BOND   = 1'b0,
        KIND_ANGLE  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [SCFG_W-1:0] strand_count;
        logic [MCFG_W-1:0] masses_per_strand;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [STRAND_W-1:0] strand;
        logic [RING_W-1:0]   ring;
        logic                slot;
    } t_walk;

    typedef struct packed {
        t_kind               kind;
        logic [OFFSET_W-1:0] first;
        logic [OFFSET_W-1:0] second;
        logic [OFFSET_W-1:0] third;
        logic                last;
    } t_rec;

    function automatic logic [OFFSET_W-1:0] f_offset(input logic [MASS_W-1:0] mass);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(mass) * PROD_W'(COORD_DIM);
        return OFFSET_W'(prod);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clbw_cfg_regs.sv -----
// Configuration registers of the walker, written and read over an APB-style port.
// Depends on clbw_pkg.
`default_nettype none
module clbw_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [clbw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [clbw_pkg::APB_DW-1:0]   pwdata,
    output logic      [clbw_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output clbw_pkg::t_cfg                     o_cfg
);
    import clbw_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign pready  = 1'b1;
    assign w_idx   = t_reg_idx'(paddr[2]);
    assign w_write = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strand_count      <= SCFG_W'(2);
            r_cfg.masses_per_strand <= MCFG_W'(3);
        end else if (w_write) begin
            unique case (w_idx)
                REG_STRAND_COUNT: r_cfg.strand_count      <= pwdata[SCFG_W-1:0];
                REG_MASSES:       r_cfg.masses_per_strand <= pwdata[MCFG_W-1:0];
                default:          r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STRAND_COUNT: prdata = APB_DW'(r_cfg.strand_count);
            REG_MASSES:       prdata = APB_DW'(r_cfg.masses_per_strand);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/clbw_step.sv -----
// One step of the walk: from the walk position, the configuration and the
// restart flag it forms the next position and the record. Depends on clbw_pkg.
`default_nettype none
module clbw_step (
    input  wire clbw_pkg::t_walk i_state,
    input  wire clbw_pkg::t_cfg  i_cfg,
    input  wire logic            i_restart,
    output clbw_pkg::t_walk      o_next,
    output clbw_pkg::t_rec       o_rec
);
    import clbw_pkg::*;

    logic [ESC_W-1:0]    w_s_eff;
    logic [EMC_W-1:0]    w_m_eff;
    logic [ESC_W-1:0]    w_s_top;
    logic [EMC_W-1:0]    w_m_top;
    t_walk               w_cur;
    logic                w_s_last;
    logic                w_r_last;
    logic                w_wrap;
    logic [STRAND_W-1:0] w_s_adv;
    logic [RING_W-1:0]   w_r_adv;
    logic [MASS_W-1:0]   w_base;
    logic [MASS_W-1:0]   w_mass;
    logic [MASS_W-1:0]   w_prev;
    logic [MASS_W-1:0]   w_next;
    logic [MASS_W-1:0]   w_up;
    logic [MASS_W-1:0]   w_down;
    logic                w_advance;

    always_comb begin
        if (i_cfg.strand_count < SCFG_W'(2)) begin
            w_s_eff = ESC_W'(2);
        end else if (int'(i_cfg.strand_count) > MAX_STRANDS) begin
            w_s_eff = ESC_W'(MAX_STRANDS);
        end else begin
            w_s_eff = ESC_W'(i_cfg.strand_count);
        end
        if (i_cfg.masses_per_strand < MCFG_W'(3)) begin
            w_m_eff = EMC_W'(3);
        end else if (int'(i_cfg.masses_per_strand) > MAX_RING_MASSES) begin
            w_m_eff = EMC_W'(MAX_RING_MASSES);
        end else begin
            w_m_eff = EMC_W'(i_cfg.masses_per_strand);
        end
    end

    assign w_s_top = w_s_eff - ESC_W'(1);
    assign w_m_top = w_m_eff - EMC_W'(1);

    always_comb begin
        if (i_restart || ESC_W'(i_state.strand) >= w_s_eff
                || EMC_W'(i_state.ring) >= w_m_eff) begin
            w_cur = '{phase: PHASE_BOND, strand: '0, ring: '0, slot: 1'b0};
        end else begin
            w_cur = i_state;
        end
    end

    assign w_s_last = ESC_W'(w_cur.strand) == w_s_top;
    assign w_r_last = EMC_W'(w_cur.ring) == w_m_top;
    assign w_wrap   = w_s_last && w_r_last;
    assign w_r_adv  = w_r_last ? '0 : w_cur.ring + RING_W'(1);
    assign w_s_adv  = !w_r_last ? w_cur.strand
                    : (w_s_last ? '0 : w_cur.strand + STRAND_W'(1));

    assign w_base = MASS_W'(w_cur.strand) * MASS_W'(w_m_eff);
    assign w_mass = w_base + MASS_W'(w_cur.ring);
    assign w_prev = (w_cur.ring == '0) ? w_base + MASS_W'(w_m_top) : w_mass - MASS_W'(1);
    assign w_next = w_r_last ? w_base : w_mass + MASS_W'(1);
    assign w_up   = w_mass + MASS_W'(w_m_eff);
    assign w_down = w_mass - MASS_W'(w_m_eff);

    always_comb begin
        o_rec     = '0;
        w_advance = 1'b1;
        unique case (w_cur.phase)
            PHASE_BOND: begin
                o_rec.kind  = KIND_BOND;
                o_rec.first = f_offset(w_mass);
                if (!w_cur.slot) begin
                    o_rec.second = f_offset(w_next);
                    w_advance    = w_s_last;
                end else begin
                    o_rec.second = f_offset(w_up);
                end
            end
            PHASE_ANGLE: begin
                o_rec.kind   = KIND_ANGLE;
                o_rec.second = f_offset(w_mass);
                if (!w_cur.slot) begin
                    o_rec.first = f_offset(w_prev);
                    o_rec.third = f_offset(w_next);
                    w_advance   = (w_cur.strand == '0) || w_s_last;
                end else begin
                    o_rec.first = f_offset(w_down);
                    o_rec.third = f_offset(w_up);
                end
                o_rec.last = w_advance && w_wrap;
            end
            default: begin
                o_rec = '0;
            end
        endcase
    end

    always_comb begin
        if (w_advance) begin
            o_next.strand = w_s_adv;
            o_next.ring   = w_r_adv;
            o_next.slot   = 1'b0;
            o_next.phase  = w_wrap ? t_phase'(~w_cur.phase) : w_cur.phase;
        end else begin
            o_next      = w_cur;
            o_next.slot = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/cylinder_lattice_bond_angle_walker_core.sv -----
// Cylinder lattice bond and angle walker, top level.
// Each accepted item's record is registered in the single output register stage.
// Throughput is one item per cycle while m_axis_tready does not stall the output.
// Synchronous active-low reset returns the walk to its first bond, empties the
// output register and sets the registers to two strands of three masses.
`default_nettype none
module cylinder_lattice_bond_angle_walker_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [0] restart
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [47:0]                   m_axis_tdata,  // first, second, third offset
    output logic      [0:0]                    m_axis_tuser,  // [0] record kind
    output logic                               m_axis_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [clbw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [clbw_pkg::APB_DW-1:0]   pwdata,
    output logic      [clbw_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import clbw_pkg::*;

    t_cfg  w_cfg;
    t_walk r_state;
    t_walk n_state;
    t_rec  r_rec;
    t_rec  n_rec;
    logic  r_valid;
    logic  w_accept;

    clbw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    clbw_step u_step (
        .i_state   (r_state),
        .i_cfg     (w_cfg),
        .i_restart (s_axis_tdata[0]),
        .o_next    (n_state),
        .o_rec     (n_rec)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PHASE_BOND, strand: '0, ring: '0, slot: 1'b0};
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rec <= n_rec;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_rec.third, r_rec.second, r_rec.first};
    assign m_axis_tuser  = r_rec.kind;
    assign m_axis_tlast  = r_rec.last;

    a_end_is_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] == KIND_ANGLE)
        else $error("end of walk on a bond record");

    a_bond_third_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_BOND |-> m_axis_tdata[47:32] == '0)
        else $error("bond record with nonzero third offset");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output register not empty after reset");

    a_angle_slot_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.slot && r_state.phase == PHASE_ANGLE |-> r_state.strand != '0)
        else $error("cross triple pending on the first strand");

endmodule
`default_nettype wire
